// ===== rtl/core/mpfd_pkg.sv =====
package mpfd_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  // Field widths of the command and result items
  localparam int OPCODE_W = 3;
  localparam int COORD_W  = 8;
  localparam int INDEX_W  = 10;
  localparam int DATA_W   = 8;

  // Coordinate sums run one bit wider than a coordinate
  localparam int SUM_W  = COORD_W + 1;
  localparam int PAGE_W = SUM_W - 3;
  localparam int PROD_W = PAGE_W + SUM_W + 1;

  // Row flip applied to y before addressing
  localparam logic [SUM_W-1:0] ROW_FLIP = SUM_W'(3'b111);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_OUTLINE = 3'd2,
    OP_FILL    = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    SEG_PIXEL,
    SEG_TOP,
    SEG_BOTTOM,
    SEG_LEFT,
    SEG_RIGHT,
    SEG_FILL
  } seg_t;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_LOAD,
    ST_PIX,
    ST_WRITE,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic clr_wr;
    logic seg_load;
    seg_t seg;
    logic pix_rd;
    logic pix_wr;
    logic advance;
    logic pix_res;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                rect_empty;
    logic                seg_empty;
    logic                pix_ok;
    logic                scan_last;
    logic                clr_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/mpfd_cmd_if.sv =====
interface mpfd_cmd_if import mpfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [COORD_W-1:0]  pos_x;
  logic [COORD_W-1:0]  pos_y;
  logic [COORD_W-1:0]  rect_w;
  logic [COORD_W-1:0]  rect_h;
  logic                color;
  logic [INDEX_W-1:0]  byte_index;

  modport source (
    output valid, opcode, pos_x, pos_y, rect_w, rect_h, color, byte_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, pos_x, pos_y, rect_w, rect_h, color, byte_index,
    output ready
  );
endinterface

// ===== rtl/core/mpfd_rsp_if.sv =====
interface mpfd_rsp_if import mpfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              in_range;
  logic [DATA_W-1:0] read_data;

  modport source (
    output valid, in_range, read_data,
    input  ready
  );

  modport sink (
    input  valid, in_range, read_data,
    output ready
  );
endinterface

// ===== rtl/core/mpfd_ram.sv =====
module mpfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/mpfd_ctrl.sv =====
module mpfd_ctrl import mpfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  seg_t   seg_r, seg_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   seg_end;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BOOT;
      seg_r       <= SEG_PIXEL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Segment finished: empty on load, or last pixel stepped past
  always_comb begin
    seg_end = 1'b0;
    if (state_r == ST_PIX) begin
      seg_end = stat.seg_empty || (!stat.pix_ok && stat.scan_last);
    end else if (state_r == ST_WRITE) begin
      seg_end = stat.scan_last;
    end
  end

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    unique case (state_r)
      ST_BOOT: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (op_t'(stat.op))
          OP_CLEAR: state_nxt = ST_CLEAR;
          OP_PIXEL: begin
            seg_nxt   = SEG_PIXEL;
            state_nxt = ST_LOAD;
          end
          OP_OUTLINE: begin
            seg_nxt   = SEG_TOP;
            state_nxt = stat.rect_empty ? ST_DONE : ST_LOAD;
          end
          OP_FILL: begin
            seg_nxt   = SEG_FILL;
            state_nxt = stat.rect_empty ? ST_DONE : ST_LOAD;
          end
          OP_READ: state_nxt = ST_RD_WAIT;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_DONE;
      end
      ST_LOAD: state_nxt = ST_PIX;
      ST_PIX, ST_WRITE: begin
        if (seg_end) begin
          unique case (seg_r)
            SEG_TOP: begin
              seg_nxt   = SEG_BOTTOM;
              state_nxt = ST_LOAD;
            end
            SEG_BOTTOM: begin
              seg_nxt   = SEG_LEFT;
              state_nxt = ST_LOAD;
            end
            SEG_LEFT: begin
              seg_nxt   = SEG_RIGHT;
              state_nxt = ST_LOAD;
            end
            default: state_nxt = ST_DONE;
          endcase
        end else if (state_r == ST_PIX && stat.pix_ok) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_PIX;
        end
      end
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_BOOT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.seg  = seg_r;
    in_ready = 1'b0;
    unique case (state_r)
      ST_BOOT, ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DECODE: cmd.rd_issue = (op_t'(stat.op) == OP_READ);
      ST_LOAD:   cmd.seg_load = 1'b1;
      ST_PIX: begin
        cmd.pix_rd  = !stat.seg_empty && stat.pix_ok;
        cmd.advance = !stat.seg_empty && !stat.pix_ok;
        cmd.pix_res = (seg_r == SEG_PIXEL);
      end
      ST_WRITE: begin
        cmd.pix_wr  = 1'b1;
        cmd.advance = 1'b1;
      end
      ST_RD_WAIT: cmd.rd_capture = 1'b1;
      ST_DONE:    cmd.out_load   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_wr |-> $past(cmd.pix_rd))
    else $error("pixel write without preceding read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && cmd.pix_wr))
    else $error("clear and pixel write collide");

  a_take_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted command not decoded");
`endif

endmodule

// ===== rtl/core/mpfd_dpath.sv =====
module mpfd_dpath import mpfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [COORD_W-1:0]  in_pos_x,
  input  logic [COORD_W-1:0]  in_pos_y,
  input  logic [COORD_W-1:0]  in_rect_w,
  input  logic [COORD_W-1:0]  in_rect_h,
  input  logic                in_color,
  input  logic [INDEX_W-1:0]  in_byte_index,
  output logic                out_in_range,
  output logic [DATA_W-1:0]   out_read_data
);

  // Captured command
  logic [OPCODE_W-1:0] op_r;
  logic [COORD_W-1:0]  x_r, y_r, w_r, h_r;
  logic                color_r;
  logic [INDEX_W-1:0]  idx_r;

  // Scan registers
  logic [SUM_W-1:0] x1_r, ys_r, ye_r, cur_x_r, cur_y_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // Pending and delivered result
  logic              res_in_range_r, out_in_range_r;
  logic [DATA_W-1:0] res_data_r, out_data_r;

  logic [SUM_W-1:0]  x9, y9, xe, y_end, y_bot, y_next;
  logic [SUM_W-1:0]  ld_x0, ld_x1, ld_ys, ld_ye;
  logic [SUM_W-1:0]  row, cur_y_inc;
  logic [PROD_W-1:0] addr_full;
  logic [ADDR_W-1:0] pix_addr, rd_addr, wr_addr;
  logic [DATA_W-1:0] pix_mask, ram_rdata, wr_data;
  logic              clr_last, idx_ok, pix_ok, row_wrap;

  assign x9     = {1'b0, x_r};
  assign y9     = {1'b0, y_r};
  assign xe     = x9 + {1'b0, w_r} - SUM_W'(1);
  assign y_end  = y9 + {1'b0, h_r};
  assign y_bot  = y_end - SUM_W'(1);
  assign y_next = y9 + SUM_W'(1);

  // Range of one segment: columns inclusive, rows end-exclusive
  always_comb begin
    ld_x0 = x9;
    ld_x1 = xe;
    ld_ys = y9;
    ld_ye = y_end;
    unique case (cmd.seg)
      SEG_PIXEL: begin
        ld_x1 = x9;
        ld_ye = y_next;
      end
      SEG_TOP: ld_ye = y_next;
      SEG_BOTTOM: ld_ys = y_bot;
      SEG_LEFT: begin
        ld_x1 = x9;
        ld_ys = y_next;
        ld_ye = y_bot;
      end
      SEG_RIGHT: begin
        ld_x0 = xe;
        ld_ys = y_next;
        ld_ye = y_bot;
      end
      default: ;
    endcase
  end

  assign row       = cur_y_r ^ ROW_FLIP;
  assign pix_ok    = (cur_x_r < SUM_W'(SCREEN_WIDTH)) && (row < SUM_W'(SCREEN_HEIGHT));
  assign addr_full = PROD_W'(row[SUM_W-1:3]) * PROD_W'(SCREEN_WIDTH) + PROD_W'(cur_x_r);
  assign pix_addr  = addr_full[ADDR_W-1:0];
  assign pix_mask  = DATA_W'(1) << row[2:0];
  assign cur_y_inc = cur_y_r + SUM_W'(1);
  assign row_wrap  = (cur_y_inc == ye_r);
  assign clr_last  = (clr_cnt_r == ADDR_W'(STORE_BYTES - 1));
  assign idx_ok    = (32'(idx_r) < 32'(STORE_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_last ? '0 : clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r           <= in_opcode;
      x_r            <= in_pos_x;
      y_r            <= in_pos_y;
      w_r            <= in_rect_w;
      h_r            <= in_rect_h;
      color_r        <= in_color;
      idx_r          <= in_byte_index;
      res_in_range_r <= 1'b1;
      res_data_r     <= '0;
    end
    if (cmd.seg_load) begin
      x1_r    <= ld_x1;
      ys_r    <= ld_ys;
      ye_r    <= ld_ye;
      cur_x_r <= ld_x0;
      cur_y_r <= ld_ys;
    end else if (cmd.advance) begin
      if (row_wrap) begin
        cur_y_r <= ys_r;
        cur_x_r <= cur_x_r + SUM_W'(1);
      end else begin
        cur_y_r <= cur_y_inc;
      end
    end
    if (cmd.pix_res) begin
      res_in_range_r <= pix_ok;
    end
    if (cmd.rd_capture && idx_ok) begin
      res_data_r <= ram_rdata;
    end
    if (cmd.out_load) begin
      out_in_range_r <= res_in_range_r;
      out_data_r     <= res_data_r;
    end
  end

  assign rd_addr = cmd.rd_issue ? ADDR_W'(idx_r) : pix_addr;
  assign wr_addr = cmd.clr_wr ? clr_cnt_r : pix_addr;
  assign wr_data = cmd.clr_wr ? '0
                 : (color_r ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask));

  mpfd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.clr_wr || cmd.pix_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   ((cmd.rd_issue && idx_ok) || cmd.pix_rd),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  assign stat.op         = op_r;
  assign stat.rect_empty = (w_r == '0) || (h_r == '0);
  assign stat.seg_empty  = !(cur_y_r < ye_r);
  assign stat.pix_ok     = pix_ok;
  assign stat.scan_last  = row_wrap && (cur_x_r == x1_r);
  assign stat.clr_last   = clr_last;

  assign out_in_range  = out_in_range_r;
  assign out_read_data = out_data_r;

endmodule

// ===== rtl/core/mono_page_framebuffer_draw.sv =====
// Monochrome page framebuffer drawing engine. The store holds one bit per
// pixel, eight rows to a byte (byte = page * SCREEN_WIDTH + x, with the low
// three bits of y flipped), in a single-port-write, registered-read RAM.
// Every command transfer yields exactly one result transfer. After reset the
// engine sweeps the whole store to zero, one byte per cycle (STORE_BYTES =
// 1024 bytes at the default size), and holds in_ch.ready low until done.
// Each command is decoded first; a clear then sweeps the store, a read
// issues its byte read and captures the data, and an empty rectangle or a
// spare opcode goes straight to the result. Rectangles and single pixels
// walk pixel by pixel through a read-modify-write on the store port: an
// on-screen pixel is read and then written, an off-screen pixel is only
// stepped past, and each edge segment is loaded before its walk (four
// segments for an outline, one for a fill). The RAM port, shared by clear
// sweep, pixel updates and byte reads, sets the pace. A finished result sits
// in an output register, so the next command can be taken in the cycle after
// the result is loaded, while the previous result still waits to be
// collected.
module mono_page_framebuffer_draw import mpfd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  mpfd_cmd_if.sink        in_ch,
  mpfd_rsp_if.source      out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequence commands, clear sweeps and segment walks
  mpfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the command, scan coordinates, store and result registers
  mpfd_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_ch.opcode),
    .in_pos_x      (in_ch.pos_x),
    .in_pos_y      (in_ch.pos_y),
    .in_rect_w     (in_ch.rect_w),
    .in_rect_h     (in_ch.rect_h),
    .in_color      (in_ch.color),
    .in_byte_index (in_ch.byte_index),
    .out_in_range  (out_ch.in_range),
    .out_read_data (out_ch.read_data)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mpfd_pkg::*;

  // Opcodes past OP_READ are decoded as no-ops by the engine
  localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

  // Quiet cycles before the run is declared hung. The worst legal gap is a
  // full-range fill: 255 x 255 pixel steps, each on-screen one a read and a
  // write, plus the clearing sweep after reset and receiver stalls.
  localparam int QUIET_LIMIT = 300000;
  localparam int TAIL_CYCLES = 32;
  localparam int RANDOM_PER_PHASE = 185;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COORD_W-1:0]  rect_w;
    logic [COORD_W-1:0]  rect_h;
    logic                color;
    logic [INDEX_W-1:0]  byte_index;
  } draw_cmd_t;

  typedef struct packed {
    logic              in_range;
    logic [DATA_W-1:0] read_data;
  } draw_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mpfd_cmd_if cmd_ch ();
  mpfd_rsp_if rsp_ch ();

  mono_page_framebuffer_draw u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (rsp_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the page store, updated in command transfer order
  logic [DATA_W-1:0] fb_shadow [STORE_BYTES];

  // Predicted results, oldest first
  draw_rsp_t readback_q [$];

  int  cmd_gap_pct   = 0;  // percent of cycles the sender holds valid low
  int  rsp_stall_pct = 0;  // percent of cycles the receiver holds ready low
  int  quiet_cycles  = 0;
  bit  failed        = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Set or clear one pixel; return 1 when it lands inside the store. The row
  // index is y with its low three bits flipped, so rows run reversed in a page.
  function automatic bit plot(input int unsigned x, input int unsigned y,
                              input logic color);
    int unsigned row;
    int unsigned addr;
    row = y ^ 7;
    if (x >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return 1'b0;
    addr = (row >> 3) * SCREEN_WIDTH + x;
    if (addr >= STORE_BYTES) return 1'b0;
    fb_shadow[ADDR_W'(addr)][3'(row)] = color;
    return 1'b1;
  endfunction

  // Apply one command to the shadow store and form its result. Corner sums
  // run at full integer width, so large rectangles run off the screen
  // instead of wrapping back to the origin.
  function automatic draw_rsp_t render_cmd(input draw_cmd_t c);
    draw_rsp_t   r;
    int unsigned x0, y0, x_end, y_end;
    int unsigned i, j;
    r.in_range  = 1'b1;
    r.read_data = '0;
    x0    = 32'(c.pos_x);
    y0    = 32'(c.pos_y);
    x_end = x0 + 32'(c.rect_w);
    y_end = y0 + 32'(c.rect_h);
    case (c.opcode)
      OP_CLEAR: begin
        foreach (fb_shadow[k]) fb_shadow[k] = '0;
      end
      OP_PIXEL: begin
        r.in_range = plot(x0, y0, c.color);
      end
      OP_OUTLINE: begin
        if (c.rect_w != '0 && c.rect_h != '0) begin
          // top and bottom rows span the full width
          for (i = x0; i < x_end; i++) begin
            void'(plot(i, y0, c.color));
            void'(plot(i, y_end - 1, c.color));
          end
          // side columns fill in between the rows
          for (j = y0 + 1; j < y_end - 1; j++) begin
            void'(plot(x0, j, c.color));
            void'(plot(x_end - 1, j, c.color));
          end
        end
      end
      OP_FILL: begin
        for (i = x0; i < x_end; i++)
          for (j = y0; j < y_end; j++)
            void'(plot(i, j, c.color));
      end
      OP_READ: begin
        if (32'(c.byte_index) < STORE_BYTES) r.read_data = fb_shadow[c.byte_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Send one command. Enter and leave at a falling edge; valid stays high on
  // exit so back-to-back commands need no second assignment in one step.
  task automatic send_cmd(input draw_cmd_t c);
    while ($urandom_range(0, 99) < cmd_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.opcode     <= c.opcode;
    cmd_ch.pos_x      <= c.pos_x;
    cmd_ch.pos_y      <= c.pos_y;
    cmd_ch.rect_w     <= c.rect_w;
    cmd_ch.rect_h     <= c.rect_h;
    cmd_ch.color      <= c.color;
    cmd_ch.byte_index <= c.byte_index;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    // transfer taken at this edge: predict now, in transfer order
    readback_q.push_back(render_cmd(c));
    @(negedge clk);
  endtask

  // Drop valid and hold the sender until every predicted result has arrived
  task automatic wait_for_readbacks();
    cmd_ch.valid <= 1'b0;
    while (readback_q.size() != 0) @(negedge clk);
  endtask

  function automatic draw_cmd_t make_cmd(input logic [OPCODE_W-1:0] op,
                                         input int x, input int y,
                                         input int w, input int h,
                                         input logic color, input int idx);
    draw_cmd_t c;
    c.opcode     = op;
    c.pos_x      = COORD_W'(x);
    c.pos_y      = COORD_W'(y);
    c.rect_w     = COORD_W'(w);
    c.rect_h     = COORD_W'(h);
    c.color      = color;
    c.byte_index = INDEX_W'(idx);
    return c;
  endfunction

  // Receiver: stall at random, changing ready only at the falling edge
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    draw_rsp_t want;
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (readback_q.size() == 0) begin
        $display("%0t: result with nothing pending: in_range %0b read_data 0x%02h",
                 $time, rsp_ch.in_range, rsp_ch.read_data);
        failed = 1'b1;
      end else begin
        want = readback_q.pop_front();
        if (rsp_ch.in_range !== want.in_range) begin
          $display("%0t: in_range mismatch: expected %0b, actual %0b",
                   $time, want.in_range, rsp_ch.in_range);
          failed = 1'b1;
        end
        if (rsp_ch.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch: expected 0x%02h, actual 0x%02h",
                   $time, want.read_data, rsp_ch.read_data);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel
  always @(posedge clk) begin
    if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results pending",
               $time, QUIET_LIMIT, readback_q.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pixels at the screen corners and just past each edge, with readback of
  // the bytes they touch. y = 7 maps to row 0 and y = 56 to row 63.
  task automatic test_pixel_bounds();
    send_cmd(make_cmd(OP_PIXEL,   0,   7, 0, 0, 1'b1, 0));
    send_cmd(make_cmd(OP_PIXEL, 127,  56, 255, 255, 1'b1, 1023));
    send_cmd(make_cmd(OP_PIXEL,   0,   0, 0, 0, 1'b1, 0));
    send_cmd(make_cmd(OP_PIXEL, 128,   0, 0, 0, 1'b1, 0));    // x past the edge
    send_cmd(make_cmd(OP_PIXEL, 255, 255, 255, 255, 1'b1, 1023));
    send_cmd(make_cmd(OP_PIXEL,   0,  64, 0, 0, 1'b1, 0));    // row 71, off screen
    send_cmd(make_cmd(OP_READ,    0,   0, 0, 0, 1'b0, 0));
    send_cmd(make_cmd(OP_READ,  255, 255, 255, 255, 1'b1, 1023));
    send_cmd(make_cmd(OP_PIXEL, 127,  56, 0, 0, 1'b0, 0));    // clear it again
    send_cmd(make_cmd(OP_READ,    0,   0, 0, 0, 1'b0, 1023));
  endtask

  // Empty rectangles, a single-pixel outline, clipped outline and a
  // full-size fill
  task automatic test_rect_edges();
    send_cmd(make_cmd(OP_OUTLINE,  10, 10,   0,   5, 1'b1, 0));
    send_cmd(make_cmd(OP_FILL,     10, 10,   5,   0, 1'b1, 0));
    send_cmd(make_cmd(OP_OUTLINE,   3,  3,   1,   1, 1'b1, 0));
    send_cmd(make_cmd(OP_OUTLINE, 120, 60, 255, 255, 1'b1, 0));
    send_cmd(make_cmd(OP_READ,      0,  0,   0,   0, 1'b0, 1023));
    send_cmd(make_cmd(OP_FILL,      0,  0, 255, 255, 1'b1, 0));
    send_cmd(make_cmd(OP_READ,      0,  0,   0,   0, 1'b0, 512));
    send_cmd(make_cmd(OP_FILL,    120, 60,   8,   8, 1'b0, 0));
    send_cmd(make_cmd(OP_READ,      0,  0,   0,   0, 1'b0, 1023));
  endtask

  // Spare opcodes must leave the store alone; then clear and read back
  task automatic test_spare_opcodes();
    logic [OPCODE_W-1:0] op;
    for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op >= OP_SPARE_FIRST; op++)
      send_cmd(make_cmd(op, 0, 0, 255, 255, 1'b0, 0));
    send_cmd(make_cmd(OP_READ,  0, 0, 0, 0, 1'b0, 1000));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    send_cmd(make_cmd(OP_READ,  0, 0, 0, 0, 1'b0, 1000));
  endtask

  // Mixed traffic: mostly pixels and reads, fills kept small but for a rare
  // full-range fill, outlines of any size, an occasional clear or spare opcode
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int unsigned pick;
    c.pos_x      = COORD_W'($urandom);
    c.pos_y      = COORD_W'($urandom);
    c.rect_w     = COORD_W'($urandom);
    c.rect_h     = COORD_W'($urandom);
    c.color      = 1'($urandom);
    c.byte_index = INDEX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      c.opcode = OP_CLEAR;
    end else if (pick < 6) begin
      c.opcode = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end else if (pick < 40) begin
      c.opcode = OP_PIXEL;
      if ($urandom_range(0, 3) != 0) begin
        c.pos_x = COORD_W'($urandom_range(0, SCREEN_WIDTH - 1));
        c.pos_y = COORD_W'($urandom_range(0, SCREEN_HEIGHT - 1));
      end
    end else if (pick < 55) begin
      c.opcode = OP_OUTLINE;
      if ($urandom_range(0, 4) < 3) begin
        c.pos_x = COORD_W'($urandom_range(0, SCREEN_WIDTH + 12));
        c.pos_y = COORD_W'($urandom_range(0, SCREEN_HEIGHT + 6));
      end
    end else if (pick < 72) begin
      c.opcode = OP_FILL;
      // full-range fills are slow: keep them rare
      if ($urandom_range(0, 39) != 0) begin
        c.pos_x  = COORD_W'($urandom_range(0, SCREEN_WIDTH + 8));
        c.pos_y  = COORD_W'($urandom_range(0, SCREEN_HEIGHT + 6));
        c.rect_w = COORD_W'($urandom_range(0, 15));
        c.rect_h = COORD_W'($urandom_range(0, 15));
      end
    end else begin
      c.opcode = OP_READ;
    end
    return c;
  endfunction

  task automatic test_random_traffic(input int count);
    repeat (count) send_cmd(random_cmd());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (fb_shadow[k]) fb_shadow[k] = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_CLEAR;
    cmd_ch.pos_x      = '0;
    cmd_ch.pos_y      = '0;
    cmd_ch.rect_w     = '0;
    cmd_ch.rect_h     = '0;
    cmd_ch.color      = 1'b0;
    cmd_ch.byte_index = '0;
    rsp_ch.ready      = 1'b0;

    // hold reset, release at a falling edge; the clearing sweep that follows
    // is absorbed by waiting on ready
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase one: light sender gaps, heavy receiver stalls
    cmd_gap_pct   = 11;
    rsp_stall_pct = 71;
    test_pixel_bounds();
    test_rect_edges();
    test_spare_opcodes();
    test_random_traffic(RANDOM_PER_PHASE);
    wait_for_readbacks();

    // phase two: the other way round
    cmd_gap_pct   = 71;
    rsp_stall_pct = 11;
    test_random_traffic(RANDOM_PER_PHASE);
    wait_for_readbacks();

    // phase three: both sides at full rate
    cmd_gap_pct   = 0;
    rsp_stall_pct = 0;
    test_random_traffic(RANDOM_PER_PHASE);
    wait_for_readbacks();

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (readback_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, readback_q.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
